@@ hdl/eoas_pkg.sv @@
// Shared types, constants and register codes for the edit-operation alignment scorer.
`default_nettype none
package eoas_pkg;

  localparam int COUNT_WIDTH_DEF = 20;
  localparam int SCORE_W         = 25;
  localparam int LEN_W           = 16;
  localparam int COST_W          = 8;
  localparam int MINM_W          = 20;
  localparam int MINID_W         = 17;
  localparam int FRAC_W          = 16;
  localparam int CFG_DATA_W      = 20;
  localparam int CFG_IDX_W       = 3;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_MATCH   = 2'd0,
    OP_REPLACE = 2'd1,
    OP_INSERT  = 2'd2,
    OP_DELETE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT       = 2'd0,
    VERDICT_FEW_MATCHES  = 2'd1,
    VERDICT_LOW_IDENTITY = 2'd2,
    VERDICT_SPLIT        = 2'd3
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_SCORE     = 3'd0,
    REG_MISMATCH_COST   = 3'd1,
    REG_GAP_OPEN_COST   = 3'd2,
    REG_GAP_EXTEND_COST = 3'd3,
    REG_MIN_MATCHES     = 3'd4,
    REG_MIN_IDENTITY    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COST_W-1:0]  match_score;
    logic [COST_W-1:0]  mismatch_cost;
    logic [COST_W-1:0]  gap_open_cost;
    logic [COST_W-1:0]  gap_extend_cost;
    logic [MINM_W-1:0]  min_matches;
    logic [MINID_W-1:0] min_identity;
  } cfg_t;

  // One edit request after the score step has been worked out
  typedef struct packed {
    op_t                       op;
    logic [LEN_W-1:0]          len;
    logic signed [SCORE_W-1:0] aligned;
    logic                      last;
    logic signed [SCORE_W-1:0] delta;
  } item_t;

  // Score state of a finished alignment
  typedef struct packed {
    logic signed [SCORE_W-1:0] running;
    logic signed [SCORE_W-1:0] best;
    logic                      split;
  } snap_t;

endpackage
`default_nettype wire

@@ hdl/eoas_delta.sv @@
// Input register stage: score step per edit run (cost times run length, plus gap open for gaps).
`default_nettype none
module eoas_delta
  import eoas_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cfg_t                      cfg,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_op,
  input  wire logic [LEN_W-1:0]          in_run_length,
  input  wire logic signed [SCORE_W-1:0] in_aligned_score,
  input  wire logic                      in_last_op,
  input  wire logic                      item_go,
  output logic                           item_valid,
  output item_t                          item
);

  logic                      valid_r, valid_nxt;
  item_t                     item_r;
  logic                      accept;
  logic [COST_W-1:0]         factor;
  logic [COST_W+LEN_W-1:0]   prod;
  logic [SCORE_W-1:0]        mag;
  logic signed [SCORE_W-1:0] delta;

  assign in_ready = !valid_r || item_go;
  assign accept   = in_valid && in_ready;

  always_comb begin
    factor = cfg.gap_extend_cost;
    case (in_op)
      OP_MATCH:   factor = cfg.match_score;
      OP_REPLACE: factor = cfg.mismatch_cost;
      default:    factor = cfg.gap_extend_cost;
    endcase
    prod = (COST_W+LEN_W)'(factor) * (COST_W+LEN_W)'(in_run_length);
    mag  = {1'b0, prod};
    if (in_op == OP_INSERT || in_op == OP_DELETE) begin
      mag = mag + {{(SCORE_W-COST_W){1'b0}}, cfg.gap_open_cost};
    end
    if (in_op == OP_MATCH) begin
      delta = $signed(mag);
    end else begin
      delta = -$signed(mag);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_go) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.op      <= op_t'(in_op);
      item_r.len     <= in_run_length;
      item_r.aligned <= in_aligned_score;
      item_r.last    <= in_last_op;
      item_r.delta   <= delta;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

@@ hdl/eoas_accum.sv @@
// Running score, peak score, split flag and saturating base counters.
`default_nettype none
module eoas_accum
  import eoas_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   item_valid,
  input  wire item_t                  item,
  output logic                        item_go,
  input  wire logic                   snap_take,
  output logic                        snap_valid,
  output snap_t                       snap,
  output logic [COUNT_WIDTH-1:0]      snap_match,
  output logic [COUNT_WIDTH-1:0]      snap_mismatch,
  output logic [COUNT_WIDTH-1:0]      snap_insert,
  output logic [COUNT_WIDTH-1:0]      snap_delete
);

  localparam int SUM_W = ((COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W) + 1;
  localparam logic [SUM_W-1:0] CNT_MAX_EXT =
    {{(SUM_W-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [LEN_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    sat_add = (s > CNT_MAX_EXT) ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  logic signed [SCORE_W-1:0] run_r, run_nxt;
  logic signed [SCORE_W-1:0] best_r, best_nxt;
  logic                      split_r, split_nxt;
  logic [COUNT_WIDTH-1:0]    match_r, match_nxt;
  logic [COUNT_WIDTH-1:0]    mism_r, mism_nxt;
  logic [COUNT_WIDTH-1:0]    ins_r, ins_nxt;
  logic [COUNT_WIDTH-1:0]    del_r, del_nxt;
  logic                      snap_v_r, snap_v_nxt;
  snap_t                     snap_r;
  logic [COUNT_WIDTH-1:0]    snap_match_r, snap_mism_r, snap_ins_r, snap_del_r;

  logic                      snap_free;
  logic [SCORE_W:0]          sum_w;
  logic signed [SCORE_W-1:0] score_c;
  logic signed [SCORE_W-1:0] best_c;
  logic                      split_c;
  logic [COUNT_WIDTH-1:0]    match_c, mism_c, ins_c, del_c;

  assign snap_free = !snap_v_r || snap_take;
  assign item_go   = item_valid && (!item.last || snap_free);

  always_comb begin
    sum_w = {run_r[SCORE_W-1], run_r} + {item.delta[SCORE_W-1], item.delta};
    if (sum_w[SCORE_W] != sum_w[SCORE_W-1]) begin
      score_c = sum_w[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end else begin
      score_c = $signed(sum_w[SCORE_W-1:0]);
    end

    split_c = split_r;
    best_c  = best_r;
    if (!split_r) begin
      if (score_c <= 0 || (score_c >= item.aligned && !item.last)) begin
        split_c = 1'b1;
      end else if (score_c > best_r) begin
        best_c = score_c;
      end
    end

    match_c = match_r;
    mism_c  = mism_r;
    ins_c   = ins_r;
    del_c   = del_r;
    case (item.op)
      OP_MATCH:   match_c = sat_add(match_r, item.len);
      OP_REPLACE: mism_c  = sat_add(mism_r, item.len);
      OP_INSERT:  ins_c   = sat_add(ins_r, item.len);
      OP_DELETE:  del_c   = sat_add(del_r, item.len);
      default:    match_c = match_r;
    endcase
  end

  always_comb begin
    run_nxt    = run_r;
    best_nxt   = best_r;
    split_nxt  = split_r;
    match_nxt  = match_r;
    mism_nxt   = mism_r;
    ins_nxt    = ins_r;
    del_nxt    = del_r;
    snap_v_nxt = snap_take ? 1'b0 : snap_v_r;
    if (item_go) begin
      if (item.last) begin
        run_nxt    = '0;
        best_nxt   = '0;
        split_nxt  = 1'b0;
        match_nxt  = '0;
        mism_nxt   = '0;
        ins_nxt    = '0;
        del_nxt    = '0;
        snap_v_nxt = 1'b1;
      end else begin
        run_nxt   = score_c;
        best_nxt  = best_c;
        split_nxt = split_c;
        match_nxt = match_c;
        mism_nxt  = mism_c;
        ins_nxt   = ins_c;
        del_nxt   = del_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= '0;
      best_r   <= '0;
      split_r  <= 1'b0;
      match_r  <= '0;
      mism_r   <= '0;
      ins_r    <= '0;
      del_r    <= '0;
      snap_v_r <= 1'b0;
    end else begin
      run_r    <= run_nxt;
      best_r   <= best_nxt;
      split_r  <= split_nxt;
      match_r  <= match_nxt;
      mism_r   <= mism_nxt;
      ins_r    <= ins_nxt;
      del_r    <= del_nxt;
      snap_v_r <= snap_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go && item.last) begin
      snap_r.running <= score_c;
      snap_r.best    <= best_c;
      snap_r.split   <= split_c;
      snap_match_r   <= match_c;
      snap_mism_r    <= mism_c;
      snap_ins_r     <= ins_c;
      snap_del_r     <= del_c;
    end
  end

  assign snap_valid    = snap_v_r;
  assign snap          = snap_r;
  assign snap_match    = snap_match_r;
  assign snap_mismatch = snap_mism_r;
  assign snap_insert   = snap_ins_r;
  assign snap_delete   = snap_del_r;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && item.last |=> run_r == '0 && !split_r && match_r == '0)
    else $error("state not cleared after last edit");

  a_split_holds: assert property (@(posedge clk) disable iff (!rst_n)
    split_r && !(item_go && item.last) |=> split_r)
    else $error("split flag dropped inside an alignment");

  a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
    snap_v_r && !snap_take |=> snap_v_r && $stable(snap_r))
    else $error("finished alignment lost or overwritten");

endmodule
`default_nettype wire

@@ hdl/eoas_verdict.sv @@
// Verdict stage: gap and total sums, match and identity tests, result register.
`default_nettype none
module eoas_verdict
  import eoas_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire logic                   snap_valid,
  input  wire snap_t                  snap,
  input  wire logic [COUNT_WIDTH-1:0] snap_match,
  input  wire logic [COUNT_WIDTH-1:0] snap_mismatch,
  input  wire logic [COUNT_WIDTH-1:0] snap_insert,
  input  wire logic [COUNT_WIDTH-1:0] snap_delete,
  output logic                        snap_take,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  out_verdict,
  output logic [COUNT_WIDTH-1:0]      out_matched_bases,
  output logic [COUNT_WIDTH-1:0]      out_mismatched_bases,
  output logic [COUNT_WIDTH-1:0]      out_gap_bases,
  output logic [COUNT_WIDTH-1:0]      out_total_length,
  output logic signed [SCORE_W-1:0]   out_final_score
);

  localparam int MW = (COUNT_WIDTH > MINM_W) ? COUNT_WIDTH : MINM_W;
  localparam int IW = COUNT_WIDTH + MINID_W;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [COUNT_WIDTH-1:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  logic                      out_v_r, out_v_nxt;
  verdict_t                  verdict_r, verdict_c;
  logic [COUNT_WIDTH-1:0]    match_out_r, mism_out_r, gaps_out_r, total_out_r;
  logic signed [SCORE_W-1:0] score_out_r;

  logic [COUNT_WIDTH-1:0]    gaps_c, total_c;
  logic                      enough_c;
  logic [IW-1:0]             id_lhs, id_rhs;
  logic                      accept_c;

  assign snap_take = snap_valid && (!out_v_r || out_ready);

  always_comb begin
    gaps_c   = sat_add(snap_insert, snap_delete);
    total_c  = sat_add(sat_add(snap_match, snap_mismatch), gaps_c);
    enough_c = MW'(snap_match) >= MW'(cfg.min_matches);
    id_lhs   = IW'({snap_match, {FRAC_W{1'b0}}});
    id_rhs   = IW'(cfg.min_identity) * IW'(total_c);
    if (snap.split) begin
      verdict_c = VERDICT_SPLIT;
    end else if (enough_c && snap.best > snap.running) begin
      verdict_c = VERDICT_SPLIT;
    end else if (!enough_c) begin
      verdict_c = VERDICT_FEW_MATCHES;
    end else if (id_lhs < id_rhs) begin
      verdict_c = VERDICT_LOW_IDENTITY;
    end else begin
      verdict_c = VERDICT_ACCEPT;
    end
    accept_c = (verdict_c == VERDICT_ACCEPT);
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (snap_take) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      verdict_r   <= verdict_c;
      match_out_r <= accept_c ? snap_match : '0;
      mism_out_r  <= accept_c ? snap_mismatch : '0;
      gaps_out_r  <= accept_c ? gaps_c : '0;
      total_out_r <= accept_c ? total_c : '0;
      score_out_r <= accept_c ? snap.running : '0;
    end
  end

  assign out_valid            = out_v_r;
  assign out_verdict          = verdict_r;
  assign out_matched_bases    = match_out_r;
  assign out_mismatched_bases = mism_out_r;
  assign out_gap_bases        = gaps_out_r;
  assign out_total_length     = total_out_r;
  assign out_final_score      = score_out_r;

  a_reject_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && verdict_r != VERDICT_ACCEPT |->
      match_out_r == '0 && mism_out_r == '0 && gaps_out_r == '0 &&
      total_out_r == '0 && score_out_r == '0)
    else $error("rejected alignment carries counts");

  a_accept_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && verdict_r == VERDICT_ACCEPT |->
      score_out_r > 0 && total_out_r >= match_out_r && total_out_r >= gaps_out_r)
    else $error("accepted alignment with inconsistent score or length");

endmodule
`default_nettype wire

@@ hdl/edit_op_alignment_scorer.sv @@
// Top level of the edit-operation alignment scorer: register file and stage wiring.
//
//   channel  direction  handshake          carries
//   in_      in         in_valid/in_ready  one edit run: kind, length, aligned score, last flag
//   out_     out        out_valid/out_ready one verdict per alignment, counts and score
//   cfg_     in         cfg_we             register write by index, no read-back
//
// One edit request per cycle unless the stages ahead hold it; the score step multiply sits in the input stage.
// An alignment's last request passes the input stage and the finished-alignment register;
// gap sums, the identity multiply and the tests share the cycle ahead of the result register.
// With the result and finished-alignment registers full and out_ready low, the next last
// request waits; other requests do not wait on these registers.
// Synchronous active-low reset clears the score state, the registers to defaults, all valids.
`default_nettype none
module edit_op_alignment_scorer
  import eoas_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_op,
  input  wire logic [LEN_W-1:0]          in_run_length,
  input  wire logic signed [SCORE_W-1:0] in_aligned_score,
  input  wire logic                      in_last_op,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [1:0]                     out_verdict,
  output logic [COUNT_WIDTH-1:0]         out_matched_bases,
  output logic [COUNT_WIDTH-1:0]         out_mismatched_bases,
  output logic [COUNT_WIDTH-1:0]         out_gap_bases,
  output logic [COUNT_WIDTH-1:0]         out_total_length,
  output logic signed [SCORE_W-1:0]      out_final_score
);

  cfg_t                   cfg_r, cfg_nxt;
  logic                   item_go, item_valid;
  item_t                  item;
  logic                   snap_take, snap_valid;
  snap_t                  snap;
  logic [COUNT_WIDTH-1:0] snap_match, snap_mismatch, snap_insert, snap_delete;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MATCH_SCORE:     cfg_nxt.match_score     = cfg_data[COST_W-1:0];
        REG_MISMATCH_COST:   cfg_nxt.mismatch_cost   = cfg_data[COST_W-1:0];
        REG_GAP_OPEN_COST:   cfg_nxt.gap_open_cost   = cfg_data[COST_W-1:0];
        REG_GAP_EXTEND_COST: cfg_nxt.gap_extend_cost = cfg_data[COST_W-1:0];
        REG_MIN_MATCHES:     cfg_nxt.min_matches     = cfg_data[MINM_W-1:0];
        REG_MIN_IDENTITY:    cfg_nxt.min_identity    = cfg_data[MINID_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_score     <= COST_W'(1);
      cfg_r.mismatch_cost   <= COST_W'(3);
      cfg_r.gap_open_cost   <= COST_W'(5);
      cfg_r.gap_extend_cost <= COST_W'(3);
      cfg_r.min_matches     <= MINM_W'(25);
      cfg_r.min_identity    <= MINID_W'(58982);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  eoas_delta u_delta (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_run_length    (in_run_length),
    .in_aligned_score (in_aligned_score),
    .in_last_op       (in_last_op),
    .item_go          (item_go),
    .item_valid       (item_valid),
    .item             (item)
  );

  eoas_accum #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item          (item),
    .item_go       (item_go),
    .snap_take     (snap_take),
    .snap_valid    (snap_valid),
    .snap          (snap),
    .snap_match    (snap_match),
    .snap_mismatch (snap_mismatch),
    .snap_insert   (snap_insert),
    .snap_delete   (snap_delete)
  );

  eoas_verdict #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_verdict (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .snap_valid           (snap_valid),
    .snap                 (snap),
    .snap_match           (snap_match),
    .snap_mismatch        (snap_mismatch),
    .snap_insert          (snap_insert),
    .snap_delete          (snap_delete),
    .snap_take            (snap_take),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_verdict          (out_verdict),
    .out_matched_bases    (out_matched_bases),
    .out_mismatched_bases (out_mismatched_bases),
    .out_gap_bases        (out_gap_bases),
    .out_total_length     (out_total_length),
    .out_final_score      (out_final_score)
  );

endmodule
`default_nettype wire
